>>> src/tolerant_set_store_unit_macros.svh
// assertion macros for the tolerant set store
`ifndef TOLERANT_SET_STORE_UNIT_MACROS_SVH
`define TOLERANT_SET_STORE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define TSS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tss: same-cycle check failed");

`define TSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tss: next-cycle check failed");

`else

`define TSS_ASSERT_SAME(label, ante, cons)
`define TSS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/tss_pkg.sv
package tss_pkg;

    localparam int OP_W         = 2;
    localparam int VALUE_PORT_W = 32;
    localparam int TOL_W        = 31;
    localparam int COUNT_PORT_W = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

endpackage

>>> src/tss_match.sv
module tss_match
    import tss_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic [VALUE_WIDTH-1:0] a,
    input  logic [VALUE_WIDTH-1:0] b,
    input  logic [TOL_W-1:0]       tolerance,
    output logic                   hit
);

    localparam int DIFF_W = VALUE_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > TOL_W) ? DIFF_W : TOL_W;

    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] mag;

    // exact signed difference, one extra bit
    assign diff = $signed({a[VALUE_WIDTH-1], a}) - $signed({b[VALUE_WIDTH-1], b});
    assign mag  = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;
    assign hit  = CMP_W'(mag) < CMP_W'(tolerance);

endmodule

>>> src/tss_store.sv
module tss_store
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tolerant_set_store_unit.sv
// tolerant set store: one request at a time, one result word per request
// lookup and insert go from accept through scan and execute to the result register,
// the scan reads one entry per cycle and stops at the first match
// delete of a match moves later entries down before the result is loaded
// next word taken the cycle after the result is loaded
// reset: count 0, tolerance 1; entry memory is not cleared, no reset pass
module tolerant_set_store_unit
    import tss_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [TOL_W-1:0]               cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [OP_W-1:0]                op,
    input  logic signed [VALUE_PORT_W-1:0] value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic                           status,
    output logic [COUNT_PORT_W-1:0]        entry_count
);

`include "tolerant_set_store_unit_macros.svh"

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [TOL_W-1:0]       tol_reg;
    logic [OP_W-1:0]        op_reg, op_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [VALUE_WIDTH-1:0] in_key;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   pend_reg, pend_next;
    logic [CNT_W-1:0]       pend_idx_reg, pend_idx_next;
    logic [CNT_W-1:0]       pend_idx_m1;
    logic                   found_reg, found_next;
    logic [CNT_W-1:0]       hit_idx_reg, hit_idx_next;
    logic                   status_reg, status_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    out_found_reg, out_found_next;
    logic                    out_status_reg, out_status_next;
    logic [COUNT_PORT_W-1:0] out_count_reg, out_count_next;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [VALUE_WIDTH-1:0] mem_rdata;
    logic                   cmp_hit;
    logic                   issue;

    if (VALUE_WIDTH <= VALUE_PORT_W)
    begin : g_key_narrow
        assign in_key = value[VALUE_WIDTH-1:0];
    end
    else
    begin : g_key_wide
        // the 32-bit word zero-extends when the stored width is larger
        assign in_key = {{(VALUE_WIDTH-VALUE_PORT_W){1'b0}}, value};
    end

    tss_store #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (idx_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    tss_match #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_match (
        .a         (mem_rdata),
        .b         (key_reg),
        .tolerance (tol_reg),
        .hit       (cmp_hit)
    );

    assign pend_idx_m1 = pend_idx_reg - 1'b1;
    assign issue       = idx_reg < count_reg;
    assign in_ready    = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = pend_idx_m1[AW-1:0];
        mem_wdata       = mem_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    key_next   = in_key;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && cmp_hit)
                begin
                    found_next   = 1'b1;
                    hit_idx_next = pend_idx_reg;
                    state_next   = ST_EXEC;
                end
                else if (!pend_reg && !issue)
                begin
                    found_next = 1'b0;
                    state_next = ST_EXEC;
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = idx_reg;
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_EXEC:
            begin
                status_next = 1'b0;
                state_next  = ST_DONE;
                if (op_reg == OP_INSERT && !found_reg)
                begin
                    if (count_reg < CAP_CNT)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[AW-1:0];
                        mem_wdata  = key_reg;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = 1'b1;
                    end
                end
                else if (op_reg == OP_DELETE && found_reg)
                begin
                    idx_next   = hit_idx_reg + 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // read entry j+1, write it to j in the following cycle
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (!issue && !pend_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    pend_next     = issue;
                    pend_idx_next = idx_reg;
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = found_reg;
                    out_status_next = status_reg;
                    out_count_next  = COUNT_PORT_W'(count_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_RESET;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                tol_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        pend_idx_reg   <= pend_idx_next;
        found_reg      <= found_next;
        hit_idx_reg    <= hit_idx_next;
        status_reg     <= status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign status      = out_status_reg;
    assign entry_count = out_count_reg;

    `TSS_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CAP_CNT)
    `TSS_ASSERT_SAME(a_shift_addr, (state_reg == ST_SHIFT) && pend_reg, pend_idx_reg != '0)
    `TSS_ASSERT_SAME(a_full_no_hit, out_valid_reg && out_status_reg, !out_found_reg)
    `TSS_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_reg == ST_SCAN)

endmodule

>>> test/tolerant_set_store_unit_test.sv
module tolerant_set_store_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int STORE_DEPTH    = 64;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * STORE_DEPTH + 10;

    localparam logic [OP_W-1:0]  OP_SPARE = 2'd3;
    localparam logic [TOL_W-1:0] TOL_NONE = 31'd0;
    localparam logic [TOL_W-1:0] TOL_MAX  = 31'h7fffffff;
    localparam logic [TOL_W-1:0] TOL_ONE  = 31'h00010000;

    localparam logic signed [VALUE_PORT_W-1:0] VALUE_MAX = 32'sh7fffffff;
    localparam logic signed [VALUE_PORT_W-1:0] VALUE_MIN = 32'sh80000000;

    typedef struct packed {
        logic                    found;
        logic                    status;
        logic [COUNT_PORT_W-1:0] entry_count;
    } reply_t;

    class tolerant_set_mirror;
        logic signed [VALUE_PORT_W-1:0] members[$];
        logic [TOL_W-1:0]               tolerance;
        reply_t                         awaited[$];
        int                             mismatches;

        function new();
            tolerance  = TOL_RESET;
            mismatches = 0;
        endfunction

        function bit within_tolerance(input logic signed [VALUE_PORT_W-1:0] a,
                                      input logic signed [VALUE_PORT_W-1:0] b);
            longint gap;
            gap = longint'(a) - longint'(b);
            if (gap < 0)
                gap = -gap;
            return gap < longint'(tolerance);
        endfunction

        function void apply_request(input logic [OP_W-1:0] opc,
                                    input logic signed [VALUE_PORT_W-1:0] v);
            int     hit;
            reply_t r;
            hit = -1;
            for (int i = 0; i < members.size() && hit < 0; i++)
                if (within_tolerance(members[i], v))
                    hit = i;
            r.found  = (hit >= 0);
            r.status = 1'b0;
            if (opc == OP_INSERT)
            begin
                if (hit < 0)
                begin
                    if (members.size() >= STORE_DEPTH)
                        r.status = 1'b1;
                    else
                        members.push_back(v);
                end
            end
            else if (opc == OP_DELETE)
            begin
                if (hit >= 0)
                    members.delete(hit);
            end
            r.entry_count = COUNT_PORT_W'(members.size());
            awaited.push_back(r);
        endfunction

        function void compare_reply(input logic f, input logic s,
                                    input logic [COUNT_PORT_W-1:0] c);
            reply_t want;
            if (awaited.size() == 0)
            begin
                $error("result word arrived with nothing outstanding");
                mismatches++;
            end
            else
            begin
                want = awaited.pop_front();
                if (f !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, f);
                    mismatches++;
                end
                if (s !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, s);
                    mismatches++;
                end
                if (c !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d", want.entry_count, c);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                           clk            = 1'b0;
    logic                           rst_n          = 1'b0;
    logic                           cfg_write_en   = 1'b0;
    logic [TOL_W-1:0]               cfg_write_data = '0;
    logic                           in_valid       = 1'b0;
    logic                           in_ready;
    logic [OP_W-1:0]                op             = OP_LOOKUP;
    logic signed [VALUE_PORT_W-1:0] value          = '0;
    logic                           out_valid;
    logic                           out_ready      = 1'b0;
    logic                           found;
    logic                           status;
    logic [COUNT_PORT_W-1:0]        entry_count;

    bit                             idle_on        = 1'b1;
    bit                             long_hold_req  = 1'b0;
    logic signed [VALUE_PORT_W-1:0] cluster_base   = '0;

    tolerant_set_mirror mirror = new();

    tolerant_set_store_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .value          (value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .status         (status),
        .entry_count    (entry_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // starts and ends at a falling edge, valid left high for a following word
    task automatic drive_request(input logic [OP_W-1:0] o,
                                 input logic signed [VALUE_PORT_W-1:0] v);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        mirror.apply_request(o, v);
        @(negedge clk);
    endtask

    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (mirror.awaited.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] t);
        pause_until_drained();
        repeat (8) @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= t;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        mirror.tolerance = t;
        @(negedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(input int ins_pct, input int del_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return OP_INSERT;
        if (r < ins_pct + del_pct)
            return OP_DELETE;
        return ($urandom_range(0, 4) == 0) ? OP_SPARE : OP_LOOKUP;
    endfunction

    // mostly values near stored ones or near a cluster, so matches are common
    function automatic logic signed [VALUE_PORT_W-1:0] pick_value(input int spread);
        int                             sel;
        int                             n;
        logic signed [VALUE_PORT_W-1:0] base;
        sel = $urandom_range(0, 9);
        n   = mirror.members.size();
        if (sel == 0)
            return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
        if (sel <= 3 || n == 0)
            return $signed($urandom);
        if (sel <= 6)
            base = mirror.members[$urandom_range(0, n - 1)];
        else
            base = cluster_base;
        return base + (int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic run_random(input int n, input int ins_pct, input int del_pct,
                              input int spread);
        logic [OP_W-1:0]                o;
        logic signed [VALUE_PORT_W-1:0] v;
        repeat (n)
        begin
            o = pick_op(ins_pct, del_pct);
            v = pick_value(spread);
            drive_request(o, v);
        end
    endtask

    initial
    begin : receiver
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                hold = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            else if (hold == 0 && idle_on && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 12);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                hold--;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : monitor
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                mirror.compare_reply(found, status, entry_count);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset tolerance of one lsb
        drive_request(OP_LOOKUP, 32'sd0);
        drive_request(OP_DELETE, 32'sd0);
        drive_request(OP_INSERT, 32'sd0);
        drive_request(OP_INSERT, 32'sd0);
        drive_request(OP_INSERT, 32'sd1);
        drive_request(OP_LOOKUP, 32'sd1);
        drive_request(OP_INSERT, VALUE_MAX);
        drive_request(OP_INSERT, VALUE_MIN);
        drive_request(OP_LOOKUP, VALUE_MIN);
        drive_request(OP_SPARE, VALUE_MAX);
        drive_request(OP_DELETE, 32'sd0);
        drive_request(OP_LOOKUP, 32'sd1);
        drive_request(OP_DELETE, VALUE_MAX);
        drive_request(OP_LOOKUP, VALUE_MAX);
        drive_request(OP_INSERT, -32'sd1);

        // zero tolerance never matches
        write_tolerance(TOL_NONE);
        drive_request(OP_INSERT, 32'sd5);
        drive_request(OP_INSERT, 32'sd5);
        drive_request(OP_LOOKUP, 32'sd5);
        drive_request(OP_DELETE, 32'sd5);
        drive_request(OP_SPARE, 32'sd5);

        write_tolerance(TOL_MAX);
        drive_request(OP_LOOKUP, VALUE_MAX);
        drive_request(OP_INSERT, VALUE_MAX);
        drive_request(OP_DELETE, VALUE_MIN);

        // fill the store and hit the full refusal
        write_tolerance(TOL_NONE);
        cluster_base = $signed($urandom);
        run_random(150, 75, 10, 4);

        // near everything matches, drain by deletes
        write_tolerance(TOL_MAX);
        run_random(120, 20, 55, 1024);

        write_tolerance(TOL_ONE);
        cluster_base = $signed($urandom);
        run_random(100, 45, 25, 32'h20000);
        long_hold_req = 1'b1;
        run_random(100, 45, 25, 32'h20000);

        write_tolerance(TOL_W'($urandom_range(1, 256)));
        cluster_base = $signed($urandom);
        run_random(100, 50, 25, 512);
        pause_until_drained();
        run_random(100, 50, 25, 512);

        write_tolerance(TOL_RESET);
        cluster_base = $signed($urandom);
        run_random(150, 50, 25, 4);

        write_tolerance(TOL_W'($urandom & 32'h7fffffff));
        cluster_base = $signed($urandom);
        run_random(150, 40, 35, 32'h10000);

        write_tolerance(TOL_W'($urandom_range(1, 32'h100000)));
        cluster_base = $signed($urandom);
        pause_until_drained();
        idle_on = 1'b0;
        @(negedge clk);
        run_random(80, 45, 30, 32'h40000);

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
